[rtl/bldq_pkg.sv]
// ============================================================================
// bldq_pkg
// Shared field widths, command and status codes, and the controller/datapath
// interface types of the bounded list deque engine.
// ============================================================================
package bldq_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int ACT_W  = 3;
    localparam int WORD_W = 32;
    localparam int POS_W  = 6;
    localparam int ENT_W  = 7;
    localparam int STAT_W = 2;

    // stream packing
    localparam int S_TDATA_W = 40;   // word_in, position, zero pad
    localparam int S_POS_LSB = WORD_W;
    localparam int M_TDATA_W = 40;   // word_out, entries, zero pad
    localparam int M_ENT_LSB = WORD_W;

    localparam logic [ACT_W-1:0] ACT_PUSH_HEAD = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PUSH_TAIL = 3'd1;
    localparam logic [ACT_W-1:0] ACT_POP_HEAD  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_POP_TAIL  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_INSERT    = 3'd4;
    localparam logic [ACT_W-1:0] ACT_EXTRACT   = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

    // what an accepted transaction does to the store
    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_INS  = 2'd1;
    localparam logic [1:0] OP_REM  = 2'd2;

    typedef struct packed {
        logic load;        // capture the incoming transaction
        logic up_prime;    // first read of an upward shift
        logic up_step;     // move one entry up
        logic up_last;     // write the new word at its position
        logic dn_prime;    // read the word being removed
        logic dn_fetch;    // capture the removed word
        logic dn_step;     // move one entry down
        logic count_inc;
        logic count_dec;
        logic out_load;    // load the result register
    } cmd_t;

    typedef struct packed {
        logic [1:0] dec_op;          // op of the transaction at the input
        logic       up_at_pos;       // index equals target position
        logic       up_next_at_pos;  // index - 1 equals target position
        logic       dn_at_last;      // index + 1 equals count
        logic       dn_next_last;    // index + 2 equals count
    } sts_t;

endpackage

[rtl/bounded_list_deque_engine_core.sv]
// ============================================================================
// bounded_list_deque_engine_core
// Bounded ordered list of signed 32-bit words with head/tail push and pop and
// positional insert and extract.
// ============================================================================
// One transaction at a time. The list lives in a single-port-write,
// single-port-read RAM, so entries after the touched position are moved one
// per cycle. With n words stored, an insert at a position p below n moves the
// n - p words from p up by one and then writes the new word, an append (push
// tail, or insert at p = n) writes in place, a pop or extract at p moves the
// n - p - 1 words after p down, and a rejected or undefined command goes
// straight to the result. s_tready returns in the cycle after the result is
// loaded, and a new result waits in the engine while the previous one is still
// stalled on the output. Push tail and pop tail are therefore the fast operations,
// head operations the slowest. A new transaction is taken while the previous
// result still waits on the output. The store needs no clearing after reset.
module bounded_list_deque_engine_core #(
    parameter int CAPACITY = bldq_pkg::CAPACITY_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bldq_pkg::S_TDATA_W-1:0]  s_tdata,   // word_in[31:0], position[37:32]
    input  logic [bldq_pkg::ACT_W-1:0]      s_tuser,   // action[2:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bldq_pkg::M_TDATA_W-1:0]  m_tdata,   // word_out[31:0], entries[38:32]
    output logic [bldq_pkg::STAT_W-1:0]     m_tuser    // status[1:0]
);

    localparam int PAD_W = bldq_pkg::M_TDATA_W - bldq_pkg::WORD_W - bldq_pkg::ENT_W;

    bldq_pkg::cmd_t cmd;
    bldq_pkg::sts_t sts;

    logic signed [bldq_pkg::WORD_W-1:0] out_word;
    logic [bldq_pkg::ENT_W-1:0]         out_entries;

    bldq_ctrl u_ctrl (
        .clk      (aclk),
        .rstn     (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bldq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk         (aclk),
        .rstn        (aresetn),
        .in_action   (s_tuser),
        .in_word     (s_tdata[bldq_pkg::WORD_W-1:0]),
        .in_position (s_tdata[bldq_pkg::S_POS_LSB +: bldq_pkg::POS_W]),
        .cmd         (cmd),
        .sts         (sts),
        .out_word    (out_word),
        .out_entries (out_entries),
        .out_status  (m_tuser)
    );

    assign m_tdata = {{PAD_W{1'b0}}, out_entries, out_word};

endmodule

[rtl/bldq_ram.sv]
// ============================================================================
// bldq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ============================================================================
module bldq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/bldq_ctrl.sv]
// ============================================================================
// bldq_ctrl
// Sequencer for the deque engine: accepts a transaction, walks the shift
// over the store one entry per cycle and hands the result to the output.
// ============================================================================
module bldq_ctrl (
    input  logic             clk,
    input  logic             rstn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  bldq_pkg::sts_t   sts,
    output bldq_pkg::cmd_t   cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_UP_PRIME = 3'd1;
    localparam logic [2:0] S_UP_RUN   = 3'd2;
    localparam logic [2:0] S_UP_LAST  = 3'd3;
    localparam logic [2:0] S_DN_PRIME = 3'd4;
    localparam logic [2:0] S_DN_FETCH = 3'd5;
    localparam logic [2:0] S_DN_RUN   = 3'd6;
    localparam logic [2:0] S_FINISH   = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       valid_reg, valid_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    if (sts.dec_op == bldq_pkg::OP_INS) begin
                        state_next = S_UP_PRIME;
                    end else if (sts.dec_op == bldq_pkg::OP_REM) begin
                        state_next = S_DN_PRIME;
                    end else begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_UP_PRIME: begin
                if (sts.up_at_pos) begin
                    // nothing to shift: write in place
                    cmd.up_last   = 1'b1;
                    cmd.count_inc = 1'b1;
                    state_next    = S_FINISH;
                end else begin
                    cmd.up_prime = 1'b1;
                    state_next   = S_UP_RUN;
                end
            end
            S_UP_RUN: begin
                cmd.up_step = 1'b1;
                if (sts.up_next_at_pos) begin
                    state_next = S_UP_LAST;
                end
            end
            S_UP_LAST: begin
                cmd.up_last   = 1'b1;
                cmd.count_inc = 1'b1;
                state_next    = S_FINISH;
            end
            S_DN_PRIME: begin
                cmd.dn_prime = 1'b1;
                state_next   = S_DN_FETCH;
            end
            S_DN_FETCH: begin
                cmd.dn_fetch = 1'b1;
                if (sts.dn_at_last) begin
                    cmd.count_dec = 1'b1;
                    state_next    = S_FINISH;
                end else begin
                    state_next = S_DN_RUN;
                end
            end
            S_DN_RUN: begin
                cmd.dn_step = 1'b1;
                if (sts.dn_next_last) begin
                    cmd.count_dec = 1'b1;
                    state_next    = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        valid_next = valid_reg;
        if (cmd.out_load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign m_tvalid = valid_reg;

endmodule

[rtl/bldq_dp.sv]
// ============================================================================
// bldq_dp
// Datapath of the deque engine: command decode, occupancy, shift indexes,
// the sequence store and the result register.
// ============================================================================
module bldq_dp #(
    parameter int CAPACITY = bldq_pkg::CAPACITY_DEF
) (
    input  logic                              clk,
    input  logic                              rstn,
    input  logic [bldq_pkg::ACT_W-1:0]        in_action,
    input  logic signed [bldq_pkg::WORD_W-1:0] in_word,
    input  logic [bldq_pkg::POS_W-1:0]        in_position,
    input  bldq_pkg::cmd_t                    cmd,
    output bldq_pkg::sts_t                    sts,
    output logic signed [bldq_pkg::WORD_W-1:0] out_word,
    output logic [bldq_pkg::ENT_W-1:0]        out_entries,
    output logic [bldq_pkg::STAT_W-1:0]       out_status
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > bldq_pkg::POS_W) ? CW : bldq_pkg::POS_W;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] pos_reg;
    logic [bldq_pkg::WORD_W-1:0] word_reg;
    logic [bldq_pkg::WORD_W-1:0] removed_reg;
    logic [bldq_pkg::STAT_W-1:0] status_reg;
    logic [bldq_pkg::WORD_W-1:0] m_word_reg;
    logic [bldq_pkg::ENT_W-1:0]  m_entries_reg;
    logic [bldq_pkg::STAT_W-1:0] m_status_reg;

    logic [bldq_pkg::STAT_W-1:0] dec_status;
    logic [1:0]                  dec_op;
    logic [CW-1:0]               dec_pos;
    logic                        full, empty;
    logic [CMPW-1:0]             pos_w, cnt_w;

    logic [CW-1:0] idx_m1, idx_m2, idx_p1, idx_p2;

    logic                        rd_en, wr_en;
    logic [AW-1:0]               rd_addr, wr_addr;
    logic [bldq_pkg::WORD_W-1:0] wr_data, rd_data;

    // ---- decode of the transaction at the input
    always_comb begin
        full       = (count_reg == CW'(CAPACITY));
        empty      = (count_reg == '0);
        pos_w      = CMPW'(in_position);
        cnt_w      = CMPW'(count_reg);
        dec_status = bldq_pkg::ST_OK;
        dec_op     = bldq_pkg::OP_NONE;
        dec_pos    = CW'(in_position);
        unique case (in_action) inside
            bldq_pkg::ACT_PUSH_HEAD, bldq_pkg::ACT_PUSH_TAIL, bldq_pkg::ACT_INSERT: begin
                if (full) begin
                    dec_status = bldq_pkg::ST_FULL;
                end else if (in_action == bldq_pkg::ACT_PUSH_HEAD) begin
                    dec_op  = bldq_pkg::OP_INS;
                    dec_pos = '0;
                end else if (in_action == bldq_pkg::ACT_PUSH_TAIL) begin
                    dec_op  = bldq_pkg::OP_INS;
                    dec_pos = count_reg;
                end else if (pos_w > cnt_w) begin
                    dec_status = bldq_pkg::ST_RANGE;
                end else begin
                    dec_op = bldq_pkg::OP_INS;
                end
            end
            bldq_pkg::ACT_POP_HEAD, bldq_pkg::ACT_POP_TAIL, bldq_pkg::ACT_EXTRACT: begin
                if (empty) begin
                    dec_status = bldq_pkg::ST_EMPTY;
                end else if (in_action == bldq_pkg::ACT_POP_HEAD) begin
                    dec_op  = bldq_pkg::OP_REM;
                    dec_pos = '0;
                end else if (in_action == bldq_pkg::ACT_POP_TAIL) begin
                    dec_op  = bldq_pkg::OP_REM;
                    dec_pos = count_reg - CW'(1);
                end else if (pos_w >= cnt_w) begin
                    dec_status = bldq_pkg::ST_RANGE;
                end else begin
                    dec_op = bldq_pkg::OP_REM;
                end
            end
            default: begin
                // undefined actions leave everything as is
                dec_status = bldq_pkg::ST_OK;
            end
        endcase
    end

    // ---- shift indexes and status toward the controller
    always_comb begin
        idx_m1 = idx_reg - CW'(1);
        idx_m2 = idx_reg - CW'(2);
        idx_p1 = idx_reg + CW'(1);
        idx_p2 = idx_reg + CW'(2);

        sts.dec_op         = dec_op;
        sts.up_at_pos      = (idx_reg == pos_reg);
        sts.up_next_at_pos = (idx_m1 == pos_reg);
        sts.dn_at_last     = (idx_p1 == count_reg);
        sts.dn_next_last   = (idx_p2 == count_reg);
    end

    // ---- store port control
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = idx_m1[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = idx_reg[AW-1:0];
        wr_data = rd_data;
        if (cmd.up_prime) begin
            rd_en   = 1'b1;
            rd_addr = idx_m1[AW-1:0];
        end
        if (cmd.up_step) begin
            wr_en = 1'b1;
            if (!sts.up_next_at_pos) begin
                rd_en   = 1'b1;
                rd_addr = idx_m2[AW-1:0];
            end
        end
        if (cmd.up_last) begin
            wr_en   = 1'b1;
            wr_addr = pos_reg[AW-1:0];
            wr_data = word_reg;
        end
        if (cmd.dn_prime) begin
            rd_en   = 1'b1;
            rd_addr = pos_reg[AW-1:0];
        end
        if (cmd.dn_fetch && !sts.dn_at_last) begin
            rd_en   = 1'b1;
            rd_addr = idx_p1[AW-1:0];
        end
        if (cmd.dn_step) begin
            wr_en = 1'b1;
            if (!sts.dn_next_last) begin
                rd_en   = 1'b1;
                rd_addr = idx_p2[AW-1:0];
            end
        end
    end

    bldq_ram #(
        .WIDTH (bldq_pkg::WORD_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        count_next = count_reg;
        if (cmd.count_inc) begin
            count_next = count_reg + CW'(1);
        end else if (cmd.count_dec) begin
            count_next = count_reg - CW'(1);
        end

        idx_next = idx_reg;
        if (cmd.load) begin
            // inserts shift from the tail down to the target, removals upward
            idx_next = (dec_op == bldq_pkg::OP_INS) ? count_reg : dec_pos;
        end else if (cmd.up_step) begin
            idx_next = idx_m1;
        end else if (cmd.dn_step) begin
            idx_next = idx_p1;
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        idx_reg <= idx_next;
        if (cmd.load) begin
            pos_reg     <= dec_pos;
            word_reg    <= in_word;
            removed_reg <= '0;
            status_reg  <= dec_status;
        end
        if (cmd.dn_fetch) begin
            removed_reg <= rd_data;
        end
        if (cmd.out_load) begin
            m_word_reg    <= removed_reg;
            m_entries_reg <= bldq_pkg::ENT_W'(count_reg);
            m_status_reg  <= status_reg;
        end
    end

    assign out_word    = m_word_reg;
    assign out_entries = m_entries_reg;
    assign out_status  = m_status_reg;

endmodule

[rtl/bldq_checker.sv]
// ============================================================================
// bldq_checker
// Port-level checks of the deque engine result stream, bound to the core.
// ============================================================================
module bldq_checker #(
    parameter int CAPACITY = bldq_pkg::CAPACITY_DEF
) (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [bldq_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [bldq_pkg::STAT_W-1:0]     m_tuser
);

    logic [bldq_pkg::ENT_W-1:0]  ent;
    logic [bldq_pkg::WORD_W-1:0] wout;

    assign ent  = m_tdata[bldq_pkg::M_ENT_LSB +: bldq_pkg::ENT_W];
    assign wout = m_tdata[bldq_pkg::WORD_W-1:0];

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a rejected command removes nothing
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != bldq_pkg::ST_OK) |-> wout == '0)
        else $error("nonzero word on rejected command");

    a_full_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == bldq_pkg::ST_FULL) |-> ent == bldq_pkg::ENT_W'(CAPACITY))
        else $error("full status with wrong count");

    a_empty_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == bldq_pkg::ST_EMPTY) |-> ent == '0)
        else $error("empty status with nonzero count");

endmodule

bind bounded_list_deque_engine_core bldq_checker #(
    .CAPACITY (CAPACITY)
) u_bldq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[tb/bounded_list_deque_engine_core_tb.sv]
// ============================================================================
// bounded_list_deque_engine_core_tb
// Self-checking bench for the list deque engine. Commands are driven on the
// s_ stream from a pending queue and mirrored into a local list model. Every
// result on the m_ stream is checked field by field against the oldest
// predicted result. The bench runs directed corner commands first, then
// random growth and shrink episodes, under changing backpressure.
// ============================================================================
module bounded_list_deque_engine_core_tb;

    localparam int CAP       = bldq_pkg::CAPACITY_DEF;
    localparam int CYC_LIMIT = 1000000;
    localparam int HOLD_CYC  = 300;
    localparam int DRAIN_CYC = 100;

    // actions the block must ignore
    localparam logic [bldq_pkg::ACT_W-1:0] ACT_UNDEF_6 = 3'd6;
    localparam logic [bldq_pkg::ACT_W-1:0] ACT_UNDEF_7 = 3'd7;

    typedef struct packed {
        logic [bldq_pkg::ACT_W-1:0]  act;
        logic [bldq_pkg::WORD_W-1:0] word;
        logic [bldq_pkg::POS_W-1:0]  pos;
    } list_cmd_t;

    typedef struct packed {
        logic [bldq_pkg::WORD_W-1:0] word;
        logic [bldq_pkg::ENT_W-1:0]  entries;
        logic [bldq_pkg::STAT_W-1:0] status;
    } list_res_t;

    logic                            aclk;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [bldq_pkg::S_TDATA_W-1:0]  s_tdata  = '0;
    logic [bldq_pkg::ACT_W-1:0]      s_tuser  = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [bldq_pkg::M_TDATA_W-1:0]  m_tdata;
    logic [bldq_pkg::STAT_W-1:0]     m_tuser;

    list_cmd_t                   pend_cmds[$];
    list_res_t                   want_results[$];
    logic [bldq_pkg::WORD_W-1:0] list_mem [CAP];
    int                          list_len      = 0;
    int                          err_cnt       = 0;
    int                          cyc_cnt       = 0;
    int                          send_idle_pct = 0;
    int                          recv_idle_pct = 0;
    logic                        in_fire       = 1'b0;
    logic                        hold_req      = 1'b0;
    logic                        hold_ack      = 1'b0;
    int                          hold_left     = 0;

    bounded_list_deque_engine_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    // Applies one command to the local list and returns what the block must answer.
    function automatic list_res_t apply_list_cmd(input list_cmd_t c);
        list_res_t r;
        int        at;
        r = '0;
        r.status = bldq_pkg::ST_OK;
        case (c.act)
            bldq_pkg::ACT_PUSH_HEAD, bldq_pkg::ACT_PUSH_TAIL, bldq_pkg::ACT_INSERT: begin
                if (list_len >= CAP) begin
                    r.status = bldq_pkg::ST_FULL;
                end else if (c.act == bldq_pkg::ACT_INSERT && int'(c.pos) > list_len) begin
                    r.status = bldq_pkg::ST_RANGE;
                end else begin
                    at = (c.act == bldq_pkg::ACT_PUSH_HEAD) ? 0 :
                         (c.act == bldq_pkg::ACT_PUSH_TAIL) ? list_len : int'(c.pos);
                    for (int i = list_len; i > at; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[at] = c.word;
                    list_len++;
                end
            end
            bldq_pkg::ACT_POP_HEAD, bldq_pkg::ACT_POP_TAIL, bldq_pkg::ACT_EXTRACT: begin
                if (list_len == 0) begin
                    r.status = bldq_pkg::ST_EMPTY;
                end else if (c.act == bldq_pkg::ACT_EXTRACT && int'(c.pos) >= list_len) begin
                    r.status = bldq_pkg::ST_RANGE;
                end else begin
                    at = (c.act == bldq_pkg::ACT_POP_HEAD) ? 0 :
                         (c.act == bldq_pkg::ACT_POP_TAIL) ? list_len - 1 : int'(c.pos);
                    r.word = list_mem[at];
                    for (int i = at; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            end
            default: ;
        endcase
        r.entries = list_len[bldq_pkg::ENT_W-1:0];
        return r;
    endfunction

    // command driver
    always @(negedge aclk) begin : drive_cmd
        logic      nxt_valid;
        list_cmd_t it;
        nxt_valid = s_tvalid && !in_fire;
        if (!nxt_valid && aresetn && pend_cmds.size() != 0 &&
            $urandom_range(99) >= send_idle_pct) begin
            it = pend_cmds.pop_front();
            s_tdata   <= {{(bldq_pkg::S_TDATA_W-bldq_pkg::WORD_W-bldq_pkg::POS_W){1'b0}},
                          it.pos, it.word};
            s_tuser   <= it.act;
            nxt_valid = 1'b1;
        end
        s_tvalid <= nxt_valid;
    end

    // result ready, with an occasional long hold-off
    always @(negedge aclk) begin
        if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYC;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor: predicts on each accepted command, checks each accepted result
    always @(posedge aclk) begin : watch_streams
        list_cmd_t c;
        list_res_t want;
        in_fire <= aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                c.act  = s_tuser;
                c.word = s_tdata[bldq_pkg::WORD_W-1:0];
                c.pos  = s_tdata[bldq_pkg::S_POS_LSB +: bldq_pkg::POS_W];
                want_results.push_back(apply_list_cmd(c));
            end
            if (m_tvalid && m_tready) begin
                if (want_results.size() == 0) begin
                    $error("result transaction with no command pending: tdata %h tuser %h",
                           m_tdata, m_tuser);
                    err_cnt++;
                end else begin
                    want = want_results.pop_front();
                    if (m_tdata[bldq_pkg::WORD_W-1:0] !== want.word) begin
                        $error("word_out: expected %0d, got %0d",
                               $signed(want.word), $signed(m_tdata[bldq_pkg::WORD_W-1:0]));
                        err_cnt++;
                    end
                    if (m_tdata[bldq_pkg::M_ENT_LSB +: bldq_pkg::ENT_W] !== want.entries) begin
                        $error("entries: expected %0d, got %0d",
                               want.entries, m_tdata[bldq_pkg::M_ENT_LSB +: bldq_pkg::ENT_W]);
                        err_cnt++;
                    end
                    if (m_tuser !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_tuser);
                        err_cnt++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt == CYC_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic add_cmd(input logic [bldq_pkg::ACT_W-1:0] act,
                           input logic [bldq_pkg::WORD_W-1:0] word,
                           input logic [bldq_pkg::POS_W-1:0] pos);
        list_cmd_t c;
        c.act  = act;
        c.word = word;
        c.pos  = pos;
        pend_cmds.push_back(c);
    endtask

    task automatic wait_drain();
        while (pend_cmds.size() != 0 || s_tvalid || want_results.size() != 0)
            @(posedge aclk);
    endtask

    // Random episodes that drift the list toward full, empty or stay mixed.
    // len shadows the list length as the queued commands will leave it.
    task automatic queue_random(input int n_cmds);
        logic [bldq_pkg::ACT_W-1:0] grow_ops [3];
        logic [bldq_pkg::ACT_W-1:0] shrink_ops [3];
        list_cmd_t                  c;
        int                         len, ep_left, grow_pct, k, hi;
        grow_ops   = '{bldq_pkg::ACT_PUSH_HEAD, bldq_pkg::ACT_PUSH_TAIL, bldq_pkg::ACT_INSERT};
        shrink_ops = '{bldq_pkg::ACT_POP_HEAD, bldq_pkg::ACT_POP_TAIL, bldq_pkg::ACT_EXTRACT};
        len     = list_len;
        ep_left = 0;
        grow_pct = 50;
        k = 0;
        while (k < n_cmds) begin
            if (ep_left == 0) begin
                ep_left = $urandom_range(120, 20);
                case ($urandom_range(2))
                    0: grow_pct = 90;
                    1: grow_pct = 50;
                    default: grow_pct = 10;
                endcase
            end
            c.word = $urandom;
            c.pos  = bldq_pkg::POS_W'($urandom);
            if ($urandom_range(99) < 3) begin
                c.act = $urandom_range(1) ? ACT_UNDEF_6 : ACT_UNDEF_7;
            end else if ($urandom_range(99) < grow_pct) begin
                c.act = grow_ops[$urandom_range(2)];
                if (c.act == bldq_pkg::ACT_INSERT && $urandom_range(99) >= 8) begin
                    hi = (len > CAP - 1) ? CAP - 1 : len;
                    c.pos = bldq_pkg::POS_W'($urandom_range(hi, 0));
                end
                if (len < CAP && (c.act != bldq_pkg::ACT_INSERT || int'(c.pos) <= len))
                    len++;
                k++;
                ep_left--;
            end else begin
                c.act = shrink_ops[$urandom_range(2)];
                if (c.act == bldq_pkg::ACT_EXTRACT && len > 0 && $urandom_range(99) >= 8)
                    c.pos = bldq_pkg::POS_W'($urandom_range(len - 1, 0));
                if (len > 0 && (c.act != bldq_pkg::ACT_EXTRACT || int'(c.pos) < len))
                    len--;
                k++;
                ep_left--;
            end
            pend_cmds.push_back(c);
        end
    endtask

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 15;
        recv_idle_pct = 74;

        // empty list, ignored actions, head/tail/positional corners
        add_cmd(bldq_pkg::ACT_POP_HEAD,  32'h0000_0000, 6'd0);
        add_cmd(bldq_pkg::ACT_POP_TAIL,  32'hFFFF_FFFF, 6'd63);
        add_cmd(bldq_pkg::ACT_EXTRACT,   32'h0000_0000, 6'd0);
        add_cmd(ACT_UNDEF_6,             32'hFFFF_FFFF, 6'd63);
        add_cmd(ACT_UNDEF_7,             32'h5555_5555, 6'd21);
        add_cmd(bldq_pkg::ACT_PUSH_HEAD, 32'h7FFF_FFFF, 6'd42);
        add_cmd(bldq_pkg::ACT_PUSH_TAIL, 32'h8000_0000, 6'd0);
        add_cmd(bldq_pkg::ACT_INSERT,    32'hFFFF_FFFF, 6'd0);
        add_cmd(bldq_pkg::ACT_INSERT,    32'h0000_0000, 6'd3);   // position equals count
        add_cmd(bldq_pkg::ACT_INSERT,    32'hAAAA_AAAA, 6'd63);
        add_cmd(bldq_pkg::ACT_INSERT,    32'h1234_5678, 6'd2);
        add_cmd(bldq_pkg::ACT_EXTRACT,   32'h0000_0000, 6'd63);
        add_cmd(bldq_pkg::ACT_EXTRACT,   32'h0000_0000, 6'd0);
        add_cmd(bldq_pkg::ACT_EXTRACT,   32'h0000_0000, 6'd2);
        add_cmd(bldq_pkg::ACT_POP_TAIL,  32'h0000_0000, 6'd0);
        add_cmd(bldq_pkg::ACT_POP_HEAD,  32'h0000_0000, 6'd0);
        add_cmd(bldq_pkg::ACT_EXTRACT,   32'h0000_0000, 6'd1);   // position equals count
        add_cmd(bldq_pkg::ACT_POP_TAIL,  32'h0000_0000, 6'd0);
        add_cmd(bldq_pkg::ACT_POP_HEAD,  32'h0000_0000, 6'd0);
        queue_random(500);
        wait_drain();

        send_idle_pct = 74;
        recv_idle_pct = 15;
        queue_random(500);
        wait_drain();

        // no idling; long receiver hold-off while commands keep coming
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = !hold_req;
        queue_random(500);
        wait_drain();

        repeat (DRAIN_CYC) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/bldq_pkg.sv
rtl/bldq_ram.sv
rtl/bldq_ctrl.sv
rtl/bldq_dp.sv
rtl/bounded_list_deque_engine_core.sv
rtl/bldq_checker.sv
tb/bounded_list_deque_engine_core_tb.sv
